/* src/drnm_pkg.sv */
package drnm_pkg;

  localparam int MAX_PARTICLES = 4096;
  localparam int CNT_W         = $clog2(MAX_PARTICLES + 1);
  localparam int IDX_W         = 12;
  localparam int ETA_W         = 18;
  localparam int PHI_W         = 16;
  localparam int PDG_W         = 25;
  localparam int DIST_W        = 32;

  // Absolute eta gap fits ETA_W bits, absolute wrapped phi gap fits PHI_W + 1 bits.
  localparam int AE_W = ETA_W;
  localparam int AP_W = PHI_W + 1;
  localparam int SUM_W = 2 * AE_W + 1;

  localparam logic [7:0]        STATUS_WANTED_RESET = 8'd1;
  localparam logic              STATUS_ANY_RESET    = 1'b1;
  localparam logic [15:0]       DR_LIMIT_RESET      = 16'd2086;
  localparam logic [DIST_W-1:0] LIMIT_SQ_RESET      = 32'd4351396;

  typedef enum logic [1:0] {
    REG_STATUS_WANTED = 2'd0,
    REG_STATUS_ANY    = 2'd1,
    REG_DR_LIMIT      = 2'd2
  } drnm_reg_t;

  typedef enum logic {
    CMD_REF      = 1'b0,
    CMD_PARTICLE = 1'b1
  } drnm_cmd_t;

  typedef struct packed {
    drnm_cmd_t cmd;
    logic      last;
    logic      take;
  } drnm_ctl_t;

  // Neutrinos and the lightest neutralino never take part in the match.
  function automatic logic excluded_id(input logic signed [PDG_W-1:0] id);
    logic signed [PDG_W-1:0] a;
    a = id[PDG_W-1] ? -id : id;
    return (a == 25'sd12) || (a == 25'sd14) || (a == 25'sd16) ||
           (a == 25'sd18) || (a == 25'sd1000022);
  endfunction

endpackage

/* src/delta_r_nearest_match.sv */
// Nearest-match search in (eta, phi) for a stream of particles.
// Input channel (in_valid/in_ready): an item with cmd = reference latches
// the reference direction and restarts the search; cmd = particle items
// follow, and the one flagged last closes the list. A reference with last
// set is an empty list and yields a no-match result straight away.
// Output channel (out_valid/out_ready): one result per closed list with
// found, match_index, best_dist_sq (squared limit when nothing matched) and
// overflow for lists longer than MAX_PARTICLES.
// Config channel (cfg_valid/cfg_ready, always ready): index 0 status_wanted,
// 1 status_any, 2 dr_limit; other indexes are ignored. A new limit applies
// from the next restart.
// Throughput: one item per cycle while in_ready is high, set by the
// combinational compare and update of the running minimum. A closing
// item passes abs differences, squares and update to the output register.
// A result waiting in the output register does not block input; the
// pipeline fills behind it and in_ready drops only when the closing item of
// the next list reaches the update stage with the output still full.
// Reset (rst, synchronous): registers go to their defaults, the reference
// direction to zero and the search state to an empty list.
module delta_r_nearest_match (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  cmd,
  input  logic signed [drnm_pkg::ETA_W-1:0]     eta,
  input  logic        [drnm_pkg::PHI_W-1:0]     phi,
  input  logic        [7:0]                     status,
  input  logic signed [drnm_pkg::PDG_W-1:0]     pdg_id,
  input  logic                                  last,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  found,
  output logic        [drnm_pkg::IDX_W-1:0]     match_index,
  output logic        [drnm_pkg::DIST_W-1:0]    best_dist_sq,
  output logic                                  overflow,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic        [1:0]                     cfg_index,
  input  logic        [15:0]                    cfg_data
);
  import drnm_pkg::*;

  // Configuration
  logic [7:0]        status_wanted;
  logic              status_any;
  logic [15:0]       dr_limit;
  logic [DIST_W-1:0] limit_sq;

  // Reference direction
  logic signed [ETA_W-1:0] ref_eta;
  logic [PHI_W-1:0]        ref_phi;

  // Running search state
  logic [DIST_W-1:0] best_sq;
  logic [IDX_W-1:0]  best_index;
  logic              have_match;
  logic [CNT_W-1:0]  particle_count;
  logic              overflow_flag;

  // Search state after the item in the update stage
  logic [DIST_W-1:0] best_sq_next;
  logic [IDX_W-1:0]  best_index_next;
  logic              have_match_next;
  logic [CNT_W-1:0]  particle_count_next;
  logic              overflow_flag_next;

  drnm_ctl_t         in_ctl;
  logic              in_accept;
  logic              s2_valid;
  logic              s2_ready;
  drnm_ctl_t         s2_ctl;
  logic [DIST_W-1:0] s2_dist;
  logic              s2_big;
  logic              adv_c;
  logic              out_load;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      status_wanted <= STATUS_WANTED_RESET;
      status_any    <= STATUS_ANY_RESET;
      dr_limit      <= DR_LIMIT_RESET;
      limit_sq      <= LIMIT_SQ_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (drnm_reg_t'(cfg_index))
          REG_STATUS_WANTED: status_wanted <= cfg_data[7:0];
          REG_STATUS_ANY:    status_any    <= cfg_data[0];
          REG_DR_LIMIT:      dr_limit      <= cfg_data;
          default: ;
        endcase
      end
      // Squared radius is registered; writes must occur only when idle, not enforced.
      limit_sq <= dr_limit * dr_limit;
    end
  end

  // Filter on the way in: status match (or wildcard) and no invisible ids.
  assign in_ctl.cmd  = drnm_cmd_t'(cmd);
  assign in_ctl.last = last;
  assign in_ctl.take = (status_any || (status == status_wanted)) && !excluded_id(pdg_id);

  assign in_accept = in_valid && in_ready;

  // Latch the direction at accept so the very next particle sees it.
  always_ff @(posedge clk) begin
    if (rst) begin
      ref_eta <= '0;
      ref_phi <= '0;
    end else if (in_accept && (in_ctl.cmd == CMD_REF)) begin
      ref_eta <= eta;
      ref_phi <= phi;
    end
  end

  drnm_dist u_dist (
    .clk      (clk),
    .rst      (rst),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .up_ctl   (in_ctl),
    .up_eta   (eta),
    .up_phi   (phi),
    .ref_eta  (ref_eta),
    .ref_phi  (ref_phi),
    .dn_valid (s2_valid),
    .dn_ready (s2_ready),
    .dn_ctl   (s2_ctl),
    .dn_dist  (s2_dist),
    .dn_big   (s2_big)
  );

  // Only a closing item needs room in the output register.
  assign s2_ready = !s2_ctl.last || !out_valid || out_ready;
  assign adv_c    = s2_valid && s2_ready;
  assign out_load = adv_c && s2_ctl.last;

  // Update stage: compare against the running minimum and advance the count.
  always_comb begin
    best_sq_next        = best_sq;
    best_index_next     = best_index;
    have_match_next     = have_match;
    particle_count_next = particle_count;
    overflow_flag_next  = overflow_flag;
    if (s2_ctl.cmd == CMD_REF) begin
      best_sq_next        = limit_sq;
      best_index_next     = '0;
      have_match_next     = 1'b0;
      particle_count_next = '0;
      overflow_flag_next  = 1'b0;
    end else if (particle_count >= CNT_W'(MAX_PARTICLES)) begin
      overflow_flag_next = 1'b1;
    end else begin
      if (s2_ctl.take && !s2_big && (s2_dist < best_sq)) begin
        best_sq_next    = s2_dist;
        best_index_next = IDX_W'(particle_count);
        have_match_next = 1'b1;
      end
      particle_count_next = particle_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best_sq        <= LIMIT_SQ_RESET;
      best_index     <= '0;
      have_match     <= 1'b0;
      particle_count <= '0;
      overflow_flag  <= 1'b0;
    end else if (adv_c) begin
      if (s2_ctl.last) begin
        // Close the list: restart with the same direction.
        best_sq        <= limit_sq;
        best_index     <= '0;
        have_match     <= 1'b0;
        particle_count <= '0;
        overflow_flag  <= 1'b0;
      end else begin
        best_sq        <= best_sq_next;
        best_index     <= best_index_next;
        have_match     <= have_match_next;
        particle_count <= particle_count_next;
        overflow_flag  <= overflow_flag_next;
      end
    end
  end

  // Output register: hold the result until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (out_load) begin
      found        <= have_match_next;
      match_index  <= best_index_next;
      best_dist_sq <= best_sq_next;
      overflow     <= overflow_flag_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    particle_count <= CNT_W'(MAX_PARTICLES))
    else $error("particle count above capacity");

  a_overflow_saturated: assert property (@(posedge clk) disable iff (rst)
    overflow_flag |-> (particle_count == CNT_W'(MAX_PARTICLES)))
    else $error("overflow set before count saturated");

  a_no_match_index: assert property (@(posedge clk) disable iff (rst)
    !have_match |-> (best_index == '0))
    else $error("index left over without a match");

  a_close_emits: assert property (@(posedge clk) disable iff (rst)
    (s2_valid && s2_ctl.last && s2_ready) |=> out_valid)
    else $error("closing item gave no result");

endmodule

/* src/drnm_dist.sv */
module drnm_dist (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   up_valid,
  output logic                                   up_ready,
  input  drnm_pkg::drnm_ctl_t                    up_ctl,
  input  logic signed [drnm_pkg::ETA_W-1:0]      up_eta,
  input  logic        [drnm_pkg::PHI_W-1:0]      up_phi,
  input  logic signed [drnm_pkg::ETA_W-1:0]      ref_eta,
  input  logic        [drnm_pkg::PHI_W-1:0]      ref_phi,
  output logic                                   dn_valid,
  input  logic                                   dn_ready,
  output drnm_pkg::drnm_ctl_t                    dn_ctl,
  output logic        [drnm_pkg::DIST_W-1:0]     dn_dist,
  output logic                                   dn_big
);
  import drnm_pkg::*;

  logic              a_valid;
  drnm_ctl_t         a_ctl;
  logic [AE_W-1:0]   ae;
  logic [AP_W-1:0]   ap;
  logic              b_valid;
  drnm_ctl_t         b_ctl;
  logic [DIST_W-1:0] b_dist;
  logic              b_big;

  logic                     a_load;
  logic                     b_load;
  logic signed [ETA_W:0]    deta;
  logic signed [PHI_W-1:0]  dphi;
  logic [AE_W:0]            ae_wide;
  logic [SUM_W-1:0]         sum;

  assign b_load   = !b_valid || dn_ready;
  assign a_load   = !a_valid || b_load;
  assign up_ready = a_load;

  // Phi difference wraps modulo one turn and reads as signed.
  assign deta    = {up_eta[ETA_W-1], up_eta} - {ref_eta[ETA_W-1], ref_eta};
  assign dphi    = ref_phi - up_phi;
  assign ae_wide = deta[ETA_W] ? (AE_W + 1)'(-deta) : (AE_W + 1)'(deta);

  assign sum = SUM_W'(ae) * SUM_W'(ae) + SUM_W'(ap) * SUM_W'(ap);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_load) begin
      a_valid <= up_valid;
    end
    if (a_load && up_valid) begin
      a_ctl <= up_ctl;
      ae    <= ae_wide[AE_W-1:0];
      ap    <= dphi[PHI_W-1] ? AP_W'(-{dphi[PHI_W-1], dphi}) : AP_W'(dphi);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_load) begin
      b_valid <= a_valid;
    end
    if (b_load && a_valid) begin
      b_ctl  <= a_ctl;
      b_dist <= sum[DIST_W-1:0];
      b_big  <= |sum[SUM_W-1:DIST_W];
    end
  end

  assign dn_valid = b_valid;
  assign dn_ctl   = b_ctl;
  assign dn_dist  = b_dist;
  assign dn_big   = b_big;

endmodule

/* sim/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import drnm_pkg::*;

  // Ids the block must never match: the three neutrinos, the fourth
  // generation one and the lightest neutralino.
  localparam int ID_NU_E        = 12;
  localparam int ID_NU_MU       = 14;
  localparam int ID_NU_TAU      = 16;
  localparam int ID_NU_4TH      = 18;
  localparam int ID_NEUTRALINO1 = 1000022;

  localparam int ETA_MAX = 131071;
  localparam int PHI_MAX = 65535;
  localparam int PDG_MAX = 9999999;

  // Register index with no register behind it; writes must be dropped.
  localparam logic [1:0] REG_SPARE = 2'd3;

  // Cycles to let the pipeline settle after the last awaited result.
  localparam int DRAIN_CYCLES = 8;

  typedef struct {
    logic              found;
    logic [IDX_W-1:0]  idx;
    logic [DIST_W-1:0] dist_sq;
    logic              ovf;
  } match_t;

  logic                    clk;
  logic                    rst          = 1'b1;
  logic                    in_valid     = 1'b0;
  logic                    in_ready;
  logic                    cmd          = 1'b0;
  logic signed [ETA_W-1:0] eta          = '0;
  logic [PHI_W-1:0]        phi          = '0;
  logic [7:0]              status       = '0;
  logic signed [PDG_W-1:0] pdg_id       = '0;
  logic                    last         = 1'b0;
  logic                    out_valid;
  logic                    out_ready    = 1'b1;
  logic                    found;
  logic [IDX_W-1:0]        match_index;
  logic [DIST_W-1:0]       best_dist_sq;
  logic                    overflow;
  logic                    cfg_valid    = 1'b0;
  logic                    cfg_ready;
  logic [1:0]              cfg_index    = '0;
  logic [15:0]             cfg_data     = '0;

  delta_r_nearest_match dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .cmd          (cmd),
    .eta          (eta),
    .phi          (phi),
    .status       (status),
    .pdg_id       (pdg_id),
    .last         (last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .found        (found),
    .match_index  (match_index),
    .best_dist_sq (best_dist_sq),
    .overflow     (overflow),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Nearest-match tracker: own copy of the registers and search state.
  // ---------------------------------------------------------------------
  logic [7:0]              wanted_q;
  logic                    any_status_q;
  logic [15:0]             limit_q;
  logic signed [ETA_W-1:0] ref_eta_q;
  logic [PHI_W-1:0]        ref_phi_q;
  logic [DIST_W-1:0]       best_sq_q;
  logic [IDX_W-1:0]        best_idx_q;
  logic                    have_q;
  int                      count_q;
  logic                    ovf_q;

  // Results still owed by the block, oldest first.
  match_t awaited_matches[$];

  int mismatches = 0;

  // Sender burst state.
  int burst_left = 0;
  bit gaps_on    = 1'b1;

  // Receiver stall pattern, rotated every cycle and replaced now and then.
  logic [7:0] ready_pattern = 8'hFF;
  int         rx_cycles     = 0;
  match_t     rx_want;

  // Reload the running minimum from the current limit and empty the list.
  task automatic restart_search();
    best_sq_q  = 32'(limit_q) * 32'(limit_q);
    best_idx_q = '0;
    have_q     = 1'b0;
    count_q    = 0;
    ovf_q      = 1'b0;
  endtask

  task automatic reset_tracker();
    wanted_q     = STATUS_WANTED_RESET;
    any_status_q = STATUS_ANY_RESET;
    limit_q      = DR_LIMIT_RESET;
    ref_eta_q    = '0;
    ref_phi_q    = '0;
    restart_search();
  endtask

  function automatic bit is_invisible(input logic signed [PDG_W-1:0] id);
    longint a;
    a = longint'(id);
    if (a < 0) a = -a;
    return a == ID_NU_E || a == ID_NU_MU || a == ID_NU_TAU || a == ID_NU_4TH ||
           a == ID_NEUTRALINO1;
  endfunction

  // Advance the search by one accepted item; queue the result it closes.
  task automatic track_nearest(input drnm_cmd_t c, input logic signed [ETA_W-1:0] e,
                               input logic [PHI_W-1:0] p, input logic [7:0] st,
                               input logic signed [PDG_W-1:0] id, input bit lst);
    match_t           m;
    logic [PHI_W-1:0] dphi_raw;
    longint           ae;
    longint           ap;
    logic [63:0]      d2;
    if (c == CMD_REF) begin
      ref_eta_q = e;
      ref_phi_q = p;
      restart_search();
      if (lst) begin
        m.found   = 1'b0;
        m.idx     = '0;
        m.dist_sq = best_sq_q;
        m.ovf     = 1'b0;
        awaited_matches.push_back(m);
      end
    end else begin
      if (count_q >= MAX_PARTICLES) begin
        ovf_q = 1'b1;
      end else begin
        if ((any_status_q || st == wanted_q) && !is_invisible(id)) begin
          // Wrap the phi gap into one turn; a half turn reads as -32768.
          dphi_raw = ref_phi_q - p;
          ap = longint'($signed(dphi_raw));
          if (ap < 0) ap = -ap;
          ae = longint'(e) - longint'(ref_eta_q);
          if (ae < 0) ae = -ae;
          d2 = ae * ae + ap * ap;
          if (d2 < {32'd0, best_sq_q}) begin
            best_sq_q  = d2[31:0];
            best_idx_q = IDX_W'(count_q);
            have_q     = 1'b1;
          end
        end
        count_q++;
      end
      if (lst) begin
        m.found   = have_q;
        m.idx     = have_q ? best_idx_q : '0;
        m.dist_sq = best_sq_q;
        m.ovf     = ovf_q;
        awaited_matches.push_back(m);
        restart_search();
      end
    end
  endtask

  task automatic report_mismatch(input string what, input longint want_v,
                                 input longint got_v);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %0d at %0t: %s expected %0d got %0d",
               mismatches, $time, what, want_v, got_v);
  endtask

  // ---------------------------------------------------------------------
  // Result side: stall on the pattern, compare each accepted result
  // against the oldest awaited one.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (awaited_matches.size() == 0) begin
        report_mismatch("result with nothing awaited, best_dist_sq", -1, best_dist_sq);
      end else begin
        rx_want = awaited_matches.pop_front();
        if (found !== rx_want.found)
          report_mismatch("found", rx_want.found, found);
        if (match_index !== rx_want.idx)
          report_mismatch("match_index", rx_want.idx, match_index);
        if (best_dist_sq !== rx_want.dist_sq)
          report_mismatch("best_dist_sq", rx_want.dist_sq, best_dist_sq);
        if (overflow !== rx_want.ovf)
          report_mismatch("overflow", rx_want.ovf, overflow);
      end
    end
    rx_cycles++;
    // Swap the stall pattern at the rx_cycles check so it drifts against the
    // sender's bursts; keep one bit set so a stall never lasts forever.
    if (rx_cycles % 97 == 0) begin
      case ($urandom_range(0, 3))
        0:       ready_pattern <= 8'hFF;
        1:       ready_pattern <= 8'($urandom) | 8'h01;
        2:       ready_pattern <= 8'hAA;
        default: ready_pattern <= 8'h01;
      endcase
    end else begin
      ready_pattern <= {ready_pattern[0], ready_pattern[7:1]};
    end
    out_ready <= ready_pattern[0];
  end

  // ---------------------------------------------------------------------
  // Item and register traffic.
  // ---------------------------------------------------------------------

  // Present one item, hold it until accepted, then advance the tracker.
  // Gaps fall between bursts; the valid drop and the next raise never share
  // a time step.
  task automatic send_item(input drnm_cmd_t c, input int e, input int p, input int st,
                           input int id, input bit lst);
    if (burst_left == 0) begin
      gaps_on = ($urandom_range(0, 4) != 0);
      if (gaps_on) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    in_valid <= 1'b1;
    cmd      <= c;
    eta      <= ETA_W'(e);
    phi      <= PHI_W'(p);
    status   <= 8'(st);
    pdg_id   <= PDG_W'(id);
    last     <= lst;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    track_nearest(c, ETA_W'(e), PHI_W'(p), 8'(st), PDG_W'(id), lst);
  endtask

  // Drop valid, wait for every awaited result, then let the pipeline drain
  // of items that close no list.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (awaited_matches.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write all three registers back to back, optionally poking the spare
  // index too. Junk goes into the unused upper data bits.
  task automatic apply_settings(input logic [7:0] wanted, input bit any_status,
                                input logic [15:0] limit, input bit poke_spare);
    logic [1:0]  idx;
    logic [15:0] val;
    for (int k = 0; k < (poke_spare ? 4 : 3); k++) begin
      case (k)
        0: begin idx = REG_STATUS_WANTED; val = {8'($urandom), wanted}; end
        1: begin idx = REG_STATUS_ANY;    val = {15'($urandom), any_status}; end
        2: begin idx = REG_DR_LIMIT;      val = limit; end
        default: begin idx = REG_SPARE;   val = 16'($urandom); end
      endcase
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= val;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      case (idx)
        REG_STATUS_WANTED: wanted_q     = val[7:0];
        REG_STATUS_ANY:    any_status_q = val[0];
        REG_DR_LIMIT:      limit_q      = val;
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic int clamp_eta(input int v);
    if (v > ETA_MAX) return ETA_MAX;
    if (v < -ETA_MAX) return -ETA_MAX;
    return v;
  endfunction

  function automatic int pick_status();
    return $urandom_range(0, 1) ? int'(wanted_q) : int'($urandom_range(0, 255));
  endfunction

  function automatic int pick_pdg();
    int id;
    case ($urandom_range(0, 9))
      0, 1: begin
        case ($urandom_range(0, 4))
          0:       id = ID_NU_E;
          1:       id = ID_NU_MU;
          2:       id = ID_NU_TAU;
          3:       id = ID_NU_4TH;
          default: id = ID_NEUTRALINO1;
        endcase
      end
      2:       id = int'($urandom_range(0, 2 * PDG_MAX)) - PDG_MAX;
      default: id = $urandom_range(1, 3000);
    endcase
    return $urandom_range(0, 1) ? -id : id;
  endfunction

  // Particle scattered around the reference on a scale set by the limit,
  // so both sides of the radius get hit.
  task automatic send_near(input bit lst);
    int spread;
    int s;
    int de;
    int dp;
    spread = int'(limit_q) + int'(limit_q) / 4 + 3;
    s  = $urandom_range(1, spread);
    de = int'($urandom_range(0, 2 * s)) - s;
    dp = int'($urandom_range(0, 2 * s)) - s;
    send_item(CMD_PARTICLE, clamp_eta(int'(ref_eta_q) + de), int'(ref_phi_q) + dp,
              pick_status(), pick_pdg(), lst);
  endtask

  // One list with random content. Mostly well formed; some lists reuse the
  // previous direction, some are empty, some get cut by a fresh reference.
  task automatic send_random_list(output int n);
    int len;
    int cut;
    int ref_e;
    bit broken;
    n = 0;
    case ($urandom_range(0, 3))
      0:       ref_e = int'($urandom_range(0, 2 * ETA_MAX)) - ETA_MAX;
      1:       ref_e = $urandom_range(0, 1) ? ETA_MAX : -ETA_MAX;
      default: ref_e = int'($urandom_range(0, 10000)) - 5000;
    endcase
    if ($urandom_range(0, 9) == 0) begin
      send_item(CMD_REF, ref_e, $urandom_range(0, PHI_MAX), $urandom_range(0, 255),
                pick_pdg(), 1'b1);
      n = 1;
    end else begin
      if ($urandom_range(0, 7) != 0) begin
        send_item(CMD_REF, ref_e, $urandom_range(0, PHI_MAX), $urandom_range(0, 255),
                  pick_pdg(), 1'b0);
        n++;
      end
      len    = ($urandom_range(0, 15) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
      broken = ($urandom_range(0, 11) == 0);
      cut    = $urandom_range(0, len - 1);
      for (int k = 0; k < len; k++) begin
        if (broken && k == cut) begin
          send_item(CMD_REF, clamp_eta(int'(ref_eta_q) + int'($urandom_range(0, 200)) - 100),
                    int'(ref_phi_q) + int'($urandom_range(0, 200)), $urandom_range(0, 255),
                    pick_pdg(), 1'b0);
          n++;
        end
        if ($urandom_range(0, 9) < 7)
          send_near(k == len - 1);
        else
          send_item(CMD_PARTICLE, int'($urandom_range(0, 2 * ETA_MAX)) - ETA_MAX,
                    $urandom_range(0, PHI_MAX), $urandom_range(0, 255), pick_pdg(),
                    k == len - 1);
        n++;
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------

  // Particles straight after reset match against the zero direction.
  // Include a phi gap that wraps and a neutrino sitting dead on target.
  task automatic test_before_reference();
    send_item(CMD_PARTICLE, 300, 65436, 1, 211, 1'b0);
    send_item(CMD_PARTICLE, 0, 0, 1, -ID_NU_E, 1'b0);
    send_item(CMD_PARTICLE, -50, 40, 1, -PDG_MAX, 1'b1);
  endtask

  // Widest limit, reference at the field corners: a full eta span, both
  // sides of the half turn, every excluded id on target, and a tie.
  task automatic test_field_extremes();
    wait_idle();
    apply_settings(8'd255, 1'b1, 16'hFFFF, 1'b1);
    send_item(CMD_REF, -ETA_MAX, PHI_MAX, 255, PDG_MAX, 1'b0);
    send_item(CMD_PARTICLE, ETA_MAX, PHI_MAX, 255, PDG_MAX, 1'b0);
    send_item(CMD_PARTICLE, -ETA_MAX, 32767, 0, -PDG_MAX, 1'b0);
    send_item(CMD_PARTICLE, -ETA_MAX, 32766, 0, 13, 1'b0);
    send_item(CMD_PARTICLE, -ETA_MAX, PHI_MAX, 0, ID_NU_E, 1'b0);
    send_item(CMD_PARTICLE, -ETA_MAX, PHI_MAX, 0, -ID_NU_MU, 1'b0);
    send_item(CMD_PARTICLE, -ETA_MAX, PHI_MAX, 0, ID_NU_TAU, 1'b0);
    send_item(CMD_PARTICLE, -ETA_MAX, PHI_MAX, 0, -ID_NU_4TH, 1'b0);
    send_item(CMD_PARTICLE, -ETA_MAX, PHI_MAX, 0, -ID_NEUTRALINO1, 1'b0);
    send_item(CMD_PARTICLE, -ETA_MAX, 0, 255, 22, 1'b0);
    // Same distance as the current best: strict compare keeps the earlier.
    send_item(CMD_PARTICLE, -ETA_MAX, 65534, 255, -22, 1'b1);
  endtask

  // Reference flagged last: empty list, squared limit at its maximum.
  task automatic test_empty_list();
    send_item(CMD_REF, 1234, 4321, 0, 0, 1'b1);
  endtask

  // Status filter on; a particle exactly on the radius must not match.
  task automatic test_status_filter();
    wait_idle();
    apply_settings(8'd7, 1'b0, 16'd100, 1'b0);
    send_item(CMD_REF, 5000, 20000, 0, 0, 1'b0);
    send_item(CMD_PARTICLE, 5060, 20080, 7, 211, 1'b0);
    send_item(CMD_PARTICLE, 5000, 20000, 8, 2212, 1'b0);
    send_item(CMD_PARTICLE, 5001, 20000, 7, -211, 1'b0);
    send_item(CMD_PARTICLE, 5000, 20000, 255, 22, 1'b1);
  endtask

  // A new limit written with a list open only takes hold at the next
  // restart.
  task automatic test_limit_mid_list();
    send_item(CMD_REF, 0, 0, 0, 0, 1'b0);
    send_item(CMD_PARTICLE, 150, 0, 7, 11, 1'b0);
    wait_idle();
    apply_settings(8'd7, 1'b0, 16'd200, 1'b0);
    send_item(CMD_PARTICLE, 150, 0, 7, 11, 1'b0);
    send_item(CMD_PARTICLE, 0, 0, 7, ID_NU_E, 1'b1);
    send_item(CMD_PARTICLE, 150, 0, 7, 11, 1'b1);
  endtask

  // Zero limit: nothing can ever be strictly inside.
  task automatic test_zero_limit();
    wait_idle();
    apply_settings(8'd0, 1'b1, 16'd0, 1'b1);
    send_item(CMD_REF, -7, PHI_MAX, 0, 0, 1'b0);
    send_item(CMD_PARTICLE, -7, PHI_MAX, 0, 211, 1'b1);
  endtask

  // Phases of random lists, each under fresh register settings.
  task automatic test_random_lists(input int n_items);
    int sent;
    int n;
    logic [7:0]  wanted;
    logic [15:0] limit;
    sent = 0;
    while (sent < n_items) begin
      wait_idle();
      case ($urandom_range(0, 3))
        0:       wanted = 8'd0;
        1:       wanted = 8'd255;
        default: wanted = 8'($urandom);
      endcase
      case ($urandom_range(0, 7))
        0:       limit = 16'd0;
        1:       limit = 16'hFFFF;
        2:       limit = 16'd1;
        3:       limit = DR_LIMIT_RESET;
        4:       limit = 16'($urandom);
        default: limit = 16'($urandom_range(2, 4000));
      endcase
      apply_settings(wanted, $urandom_range(0, 1), limit, $urandom_range(0, 3) == 0);
      repeat ($urandom_range(3, 10)) begin
        send_random_list(n);
        sent += n;
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Sequence.
  // ---------------------------------------------------------------------
  initial begin
    int settle;
    reset_tracker();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_before_reference();
    test_field_extremes();
    test_empty_list();
    test_status_filter();
    test_limit_mid_list();
    test_zero_limit();
    test_random_lists(1870);

    // Wait for the tail, bounded, then give the pipeline time to show any
    // stray result.
    in_valid <= 1'b0;
    for (settle = 0; settle < 5000 && awaited_matches.size() != 0; settle++)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (awaited_matches.size() != 0)
      report_mismatch("results never delivered", 0, awaited_matches.size());

    if (mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #6_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
